/* src/yincmnd_pkg.sv */
// Shared constants, types and state encodings for the YIN CMND threshold search block.
`default_nettype none

package yincmnd_pkg;

  localparam int DIFF_W          = 32;
  localparam int THRESH_W        = 16;
  localparam int NORM_W          = 18;
  localparam int FRAC_W          = 16;
  localparam int LAG_OUT_W       = 10;
  localparam int OUT_DATA_W      = 32;
  localparam int OUT_PAD_W       = OUT_DATA_W - NORM_W - LAG_OUT_W;
  localparam int QCNT_W          = $clog2(NORM_W + 1);
  localparam int MAX_LAG_DEFAULT = 1024;

  localparam logic [NORM_W-1:0]   NORM_MAX     = '1;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd13107;

  typedef enum logic [1:0] {
    PH_SEARCHING,
    PH_DESCENDING,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              done;
    logic [NORM_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic                 found;
    logic [LAG_OUT_W-1:0] lag;
    logic [NORM_W-1:0]    value;
  } search_res_t;

endpackage

`default_nettype wire

/* src/yincmnd_div.sv */
// Iterative restoring divider that forms the saturated Q2.16 normalized difference.
`default_nettype none

module yincmnd_div #(
  parameter int SUM_W = yincmnd_pkg::DIFF_W + $clog2(yincmnd_pkg::MAX_LAG_DEFAULT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [SUM_W-1:0]            prod,
  input  wire logic [SUM_W-1:0]            sum,
  output      yincmnd_pkg::div_res_t       res
);

  localparam int QB = yincmnd_pkg::NORM_W;

  logic [SUM_W-1:0]               rem;
  logic [QB-1:0]                  nbits;
  logic [QB-1:0]                  quot;
  logic [yincmnd_pkg::QCNT_W-1:0] cnt;
  logic                           busy;
  logic                           first;
  logic                           ovf;
  logic                           done;

  logic [SUM_W:0] cand;
  logic [SUM_W:0] diff;
  logic           ge;

  // The numerator is prod * 2^16. Its top part prod >> 2 is compared with the
  // sum first: when it is not below, the quotient exceeds 18 bits (or the sum
  // is zero) and the result saturates. Otherwise 18 restoring steps follow.
  always_comb begin
    cand = first ? {1'b0, rem} : {rem, nbits[QB-1]};
    ge   = (cand >= {1'b0, sum});
    diff = cand - {1'b0, sum};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      first <= 1'b0;
      done  <= 1'b0;
      ovf   <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        first <= 1'b1;
        ovf   <= 1'b0;
        cnt   <= '0;
      end else if (busy && first) begin
        first <= 1'b0;
        ovf   <= ge;
        if (ge) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == yincmnd_pkg::QCNT_W'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= SUM_W'(prod >> 2);
      nbits <= {prod[1:0], {yincmnd_pkg::FRAC_W{1'b0}}};
    end else if (busy && !first) begin
      rem   <= ge ? diff[SUM_W-1:0] : cand[SUM_W-1:0];
      quot  <= {quot[QB-2:0], ge};
      nbits <= {nbits[QB-2:0], 1'b0};
    end
  end

  assign res.done = done;
  assign res.quot = ovf ? yincmnd_pkg::NORM_MAX : quot;

endmodule

`default_nettype wire

/* src/yincmnd_search.sv */
// Threshold crossing and local minimum descent over the normalized values of a frame.
`default_nettype none

module yincmnd_search #(
  parameter int TW = $clog2(yincmnd_pkg::MAX_LAG_DEFAULT)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 clear,
  input  wire logic                                 update,
  input  wire logic [TW-1:0]                        tau,
  input  wire logic [yincmnd_pkg::NORM_W-1:0]       n,
  input  wire logic [yincmnd_pkg::THRESH_W-1:0]     threshold,
  output      yincmnd_pkg::search_res_t             res
);

  yincmnd_pkg::phase_t              phase;
  logic [TW-1:0]                    best_lag;
  logic [yincmnd_pkg::NORM_W-1:0]   best_value;
  logic [yincmnd_pkg::LAG_OUT_W+TW-1:0] lag_wide;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase      <= yincmnd_pkg::PH_SEARCHING;
      best_lag   <= '0;
      best_value <= yincmnd_pkg::NORM_MAX;
    end else if (update) begin
      case (phase)
        yincmnd_pkg::PH_SEARCHING: begin
          if (n < {{(yincmnd_pkg::NORM_W - yincmnd_pkg::THRESH_W){1'b0}}, threshold}) begin
            phase      <= yincmnd_pkg::PH_DESCENDING;
            best_lag   <= tau;
            best_value <= n;
          end
        end
        yincmnd_pkg::PH_DESCENDING: begin
          // Follow strictly falling values; anything else ends the descent.
          if (n < best_value) begin
            best_lag   <= tau;
            best_value <= n;
          end else begin
            phase <= yincmnd_pkg::PH_DONE;
          end
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

  assign lag_wide  = {{yincmnd_pkg::LAG_OUT_W{1'b0}}, best_lag};
  assign res.found = (phase != yincmnd_pkg::PH_SEARCHING);
  assign res.lag   = res.found ? lag_wide[yincmnd_pkg::LAG_OUT_W-1:0] : '0;
  assign res.value = res.found ? best_value : '0;

endmodule

`default_nettype wire

/* src/yin_cmnd_threshold_search.sv */
// Top level of the YIN cumulative mean normalized difference threshold search.
//
//  Channel  | Direction | Signals                          | Payload
//  ---------+-----------+----------------------------------+-------------------------------
//  s_axis   | in        | tvalid, tready, tdata, tlast     | diff_value, frame end marker
//  m_axis   | out       | tvalid, tready, tdata, tuser     | lag, normalized value, found
//  cfg      | in        | valid, ready, data               | threshold, unsigned Q0.16
//
// Each lag value is one transfer on s_axis. A value at lag one or higher is accepted, goes
// through the d*tau multiplier and the shared restoring divider (a saturation check, one
// compare/subtract per quotient bit for 18 bits, and a hand-over of the quotient), and then
// through the search update. When the saturation check trips, the divider stops right after
// it. The value at lag zero and values at or past MAX_LAG are only accepted. A frame end
// then loads the result register.
// Reset is synchronous and active high; it clears the frame state, sets the threshold to
// 0.2 and empties the result register. A result waiting on m_axis does not stop the next
// frame from starting; only the next frame's result waits for it to be taken.
`default_nettype none

module yin_cmnd_threshold_search #(
  parameter int MAX_LAG = yincmnd_pkg::MAX_LAG_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration write channel: threshold.
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [yincmnd_pkg::THRESH_W-1:0]      cfg_data,
  // Input stream.
  input  wire logic                                  s_axis_tvalid,
  output      logic                                  s_axis_tready,
  input  wire logic [yincmnd_pkg::DIFF_W-1:0]        s_axis_tdata,   // [31:0] diff_value
  input  wire logic                                  s_axis_tlast,
  // Result stream.
  output      logic                                  m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output      logic [yincmnd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [9:0] lag,
                                                                     // [27:10] normalized_value,
                                                                     // [31:28] zero
  output      logic                                  m_axis_tuser    // [0] found
);

  localparam int TW    = $clog2(MAX_LAG);
  localparam int LCW   = $clog2(MAX_LAG + 1);
  localparam int SUM_W = yincmnd_pkg::DIFF_W + TW;

  yincmnd_pkg::state_t state;
  yincmnd_pkg::state_t state_next;

  logic [yincmnd_pkg::THRESH_W-1:0] threshold;
  logic [LCW-1:0]                   lag_counter;
  logic [SUM_W-1:0]                 diff_sum;
  logic [yincmnd_pkg::DIFF_W-1:0]   d_q;
  logic [TW-1:0]                    tau_q;
  logic                             last_q;

  logic                             in_fire;
  logic                             lag_excess;
  logic                             lag_zero;
  logic                             div_start;
  logic                             search_upd;
  logic                             emit_fire;
  logic [SUM_W-1:0]                 prod;

  yincmnd_pkg::div_res_t            div_res;
  yincmnd_pkg::search_res_t         srch_res;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign lag_excess = (lag_counter >= LCW'(MAX_LAG));
  assign lag_zero   = (lag_counter == '0);
  assign cfg_ready  = 1'b1;

  // d * tau; the divider registers it on its start cycle.
  assign prod = {{TW{1'b0}}, d_q} * {{yincmnd_pkg::DIFF_W{1'b0}}, tau_q};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      yincmnd_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (lag_excess || lag_zero) begin
            state_next = s_axis_tlast ? yincmnd_pkg::ST_EMIT : yincmnd_pkg::ST_IDLE;
          end else begin
            state_next = yincmnd_pkg::ST_MUL;
          end
        end
      end
      yincmnd_pkg::ST_MUL: begin
        state_next = yincmnd_pkg::ST_DIV;
      end
      yincmnd_pkg::ST_DIV: begin
        if (div_res.done) begin
          state_next = yincmnd_pkg::ST_UPDATE;
        end
      end
      yincmnd_pkg::ST_UPDATE: begin
        state_next = last_q ? yincmnd_pkg::ST_EMIT : yincmnd_pkg::ST_IDLE;
      end
      yincmnd_pkg::ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = yincmnd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = yincmnd_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    search_upd    = 1'b0;
    emit_fire     = 1'b0;
    case (state)
      yincmnd_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      yincmnd_pkg::ST_MUL: begin
        div_start = 1'b1;
      end
      yincmnd_pkg::ST_UPDATE: begin
        // Lag one feeds the sum but is never searched.
        search_upd = (tau_q >= TW'(2));
      end
      yincmnd_pkg::ST_EMIT: begin
        emit_fire = !m_axis_tvalid || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= yincmnd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= yincmnd_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Frame counters. Values at or past MAX_LAG leave them untouched; lag zero only counts.
  always_ff @(posedge clk) begin
    if (rst || emit_fire) begin
      lag_counter <= '0;
      diff_sum    <= '0;
    end else if (in_fire && !lag_excess) begin
      lag_counter <= lag_counter + 1'b1;
      if (!lag_zero) begin
        diff_sum <= diff_sum + {{TW{1'b0}}, s_axis_tdata};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_q    <= s_axis_tdata;
      tau_q  <= lag_counter[TW-1:0];
      last_q <= s_axis_tlast;
    end
  end

  // Result register; it parts the result stream from the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_axis_tdata <= {{yincmnd_pkg::OUT_PAD_W{1'b0}}, srch_res.value, srch_res.lag};
      m_axis_tuser <= srch_res.found;
    end
  end

  yincmnd_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .prod  (prod),
    .sum   (diff_sum),
    .res   (div_res)
  );

  yincmnd_search #(
    .TW (TW)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .clear     (emit_fire),
    .update    (search_upd),
    .tau       (tau_q),
    .n         (div_res.quot),
    .threshold (threshold),
    .res       (srch_res)
  );

endmodule

`default_nettype wire

/* src/yincmnd_checker.sv */
// Port-level checks on the threshold search block, bound to its top level.
`default_nettype none

module yincmnd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [yincmnd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic                                m_axis_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A frame without a pitch reports zero lag and zero value.
  a_no_pitch_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("no-pitch result carries data");

  // A found value lies below the largest threshold, so it fits in Q0.16 below 65535.
  a_found_below: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[27:26] == 2'b00 && m_axis_tdata[25:10] != 16'hFFFF)
    else $error("found value not below threshold range");

  // Padding bits of the result stay clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
    else $error("result padding not zero");

endmodule

bind yin_cmnd_threshold_search yincmnd_checker u_checker (.*);

`default_nettype wire

/* tb/tb_yin_cmnd_threshold_search.sv */
// Self-checking testbench for the YIN normalized difference threshold search block.
`default_nettype none

module tb_yin_cmnd_threshold_search;
  timeunit 1ns;
  timeprecision 1ps;

  // A short lag limit keeps frames small enough that the limit is reached often.
  localparam int MAX_LAG_TB = 64;
  localparam logic [yincmnd_pkg::NORM_W-1:0] NORM_ONE = 18'h10000;
  // Longest stretch of cycles with no transfer on any channel before giving up.
  localparam int QUIET_LIMIT = 3000;
  // Lag values sent in each random phase.
  localparam int PHASE_ITEMS = 80;

  // Predicts the pitch result of each frame from the accepted lag values and
  // compares the block's results against it in order.
  class cmnd_scoreboard;
    logic [yincmnd_pkg::THRESH_W-1:0] thresh;
    int unsigned                      lag_limit;
    int unsigned                      tau_next;
    bit [63:0]                        dsum;
    yincmnd_pkg::phase_t              srch_phase;
    int unsigned                      best_lag;
    logic [yincmnd_pkg::NORM_W-1:0]   best_n;
    yincmnd_pkg::search_res_t         pitch_q[$];
    int unsigned                      n_items, n_frames, n_pitches, deepest_lag, n_errors;

    function new(int unsigned max_lag);
      lag_limit   = max_lag;
      thresh      = yincmnd_pkg::THRESH_RESET;
      n_items     = 0;
      n_frames    = 0;
      n_pitches   = 0;
      deepest_lag = 0;
      n_errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      tau_next   = 0;
      dsum       = '0;
      srch_phase = yincmnd_pkg::PH_SEARCHING;
      best_lag   = 0;
      best_n     = yincmnd_pkg::NORM_MAX;
    endfunction

    function void set_threshold(logic [yincmnd_pkg::THRESH_W-1:0] v);
      thresh = v;
    endfunction

    function int unsigned pending();
      return pitch_q.size();
    endfunction

    // d * tau / sum in Q2.16, saturated; a zero sum also saturates.
    function logic [yincmnd_pkg::NORM_W-1:0] norm_diff(bit [yincmnd_pkg::DIFF_W-1:0] d,
                                                       int unsigned tau);
      bit [63:0] num;
      bit [63:0] q;
      if (dsum == 0) return yincmnd_pkg::NORM_MAX;
      num = (64'(d) * 64'(tau)) << yincmnd_pkg::FRAC_W;
      q = num / dsum;
      if (q > 64'(yincmnd_pkg::NORM_MAX)) return yincmnd_pkg::NORM_MAX;
      return q[yincmnd_pkg::NORM_W-1:0];
    endfunction

    function void note_item(logic [yincmnd_pkg::DIFF_W-1:0] d, logic lst);
      logic [yincmnd_pkg::NORM_W-1:0] n;
      yincmnd_pkg::search_res_t       r;
      n_items++;
      // Lags at or past the limit leave the frame state alone.
      if (tau_next < lag_limit) begin
        if (tau_next == 0) begin
          n = NORM_ONE;
        end else begin
          dsum += 64'(d);
          n = norm_diff(d, tau_next);
        end
        // Lags zero and one are never candidates.
        if (tau_next >= 2) begin
          if (srch_phase == yincmnd_pkg::PH_SEARCHING) begin
            if (n < {2'b00, thresh}) begin
              srch_phase = yincmnd_pkg::PH_DESCENDING;
              best_lag   = tau_next;
              best_n     = n;
            end
          end else if (srch_phase == yincmnd_pkg::PH_DESCENDING) begin
            if (n < best_n) begin
              best_lag = tau_next;
              best_n   = n;
            end else begin
              srch_phase = yincmnd_pkg::PH_DONE;
            end
          end
        end
        tau_next++;
      end
      if (lst) begin
        if (srch_phase != yincmnd_pkg::PH_SEARCHING) begin
          r.found = 1'b1;
          r.lag   = best_lag[yincmnd_pkg::LAG_OUT_W-1:0];
          r.value = best_n;
          n_pitches++;
          if (best_lag > deepest_lag) deepest_lag = best_lag;
        end else begin
          r = '0;
        end
        pitch_q.push_back(r);
        n_frames++;
        clear_frame();
      end
    endfunction

    function void check_pitch(logic fnd, logic [yincmnd_pkg::LAG_OUT_W-1:0] lg,
                              logic [yincmnd_pkg::NORM_W-1:0] nv);
      yincmnd_pkg::search_res_t want;
      if (pitch_q.size() == 0) begin
        $error("result with no frame pending: found=%0d lag=%0d normalized_value=%0d",
               fnd, lg, nv);
        n_errors++;
        return;
      end
      want = pitch_q.pop_front();
      if (fnd !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, fnd);
        n_errors++;
      end
      if (lg !== want.lag) begin
        $error("lag: expected %0d, actual %0d", want.lag, lg);
        n_errors++;
      end
      if (nv !== want.value) begin
        $error("normalized_value: expected %0d, actual %0d", want.value, nv);
        n_errors++;
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [yincmnd_pkg::THRESH_W-1:0]   cfg_data = '0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [yincmnd_pkg::DIFF_W-1:0]     s_axis_tdata = '0;    // [31:0] diff_value
  logic                               s_axis_tlast = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [yincmnd_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // [9:0] lag, [27:10] normalized_value
  logic                               m_axis_tuser;  // [0] found

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned items_sent_phase = 0;

  cmnd_scoreboard sb;

  yin_cmnd_threshold_search #(
    .MAX_LAG(MAX_LAG_TB)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver decides each cycle whether it will take a result.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Transfers are sampled at the edge with the values that held just before it,
  // so the order of processes inside the time step does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_pitch(m_axis_tuser, m_axis_tdata[yincmnd_pkg::LAG_OUT_W-1:0],
                       m_axis_tdata[yincmnd_pkg::LAG_OUT_W+yincmnd_pkg::NORM_W-1:
                                    yincmnd_pkg::LAG_OUT_W]);
      end
    end
  end

  // Watchdog: the block must keep moving, so a long run with no transfer at all
  // means it has hung.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // One lag value on the input stream. The valid is dropped only when the
  // sender decides to idle, so it never toggles within a single step.
  task automatic send_item(input logic [yincmnd_pkg::DIFF_W-1:0] d, input logic lst);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    items_sent_phase++;
  endtask

  // Waits until every frame result is back, then lets the block go quiet.
  task automatic settle(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [yincmnd_pkg::THRESH_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_threshold(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [yincmnd_pkg::DIFF_W-1:0] noise_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // A frame of lag values. Most frames hold a large plateau with a dip around a
  // chosen period, which drives the search through its descent; some have the
  // dip past the end of the frame, and some are pure noise.
  task automatic send_frame(input int unsigned len);
    int unsigned kind;
    int unsigned period;
    int unsigned width;
    int unsigned base;
    int unsigned step;
    int unsigned offs;
    logic [yincmnd_pkg::DIFF_W-1:0] d;
    kind   = $urandom_range(0, 9);
    period = $urandom_range(2, len + 2);
    width  = $urandom_range(0, 5);
    base   = $urandom_range(1 << 12, 1 << 28);
    step   = $urandom_range(0, 1 << $urandom_range(0, 14));
    for (int unsigned t = 0; t < len; t++) begin
      offs = (t > period) ? t - period : period - t;
      if (kind < 2) begin
        d = noise_value();
      end else if (offs <= width) begin
        d = offs * step + $urandom_range(0, step);
      end else begin
        d = base + $urandom_range(0, base >> 1);
      end
      send_item(d, t == len - 1);
    end
  endtask

  initial begin
    int unsigned thr;
    int unsigned len;
    sb = new(MAX_LAG_TB);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset threshold of 0.2.
    // A frame of only lag zero: nothing can be found.
    send_item(32'hFFFF_FFFF, 1'b1);
    // All zero values: the sum stays zero, every value saturates, no pitch.
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    // A zero right after a full-scale value is found at lag two, and an equal
    // zero behind it ends the descent.
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    // Leading zeros then a full-scale value: the quotient overflows and saturates.
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // A plateau followed by a falling run that turns up again at lag seven.
    send_item('0, 1'b0);
    send_item(32'd1000, 1'b0);
    send_item(32'd1000, 1'b0);
    send_item(32'd1000, 1'b0);
    send_item(32'd100, 1'b0);
    send_item(32'd50, 1'b0);
    send_item(32'd10, 1'b0);
    send_item(32'd20, 1'b1);
    settle(30);

    // Random phases, each with its own threshold and flow-control mode.
    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       thr = 16'hFFFF;
        1:       thr = 0;
        3:       thr = yincmnd_pkg::THRESH_RESET;
        5:       thr = 1;
        7:       thr = 16'h8000;
        default: thr = $urandom_range(0, 16'hFFFF);
      endcase
      write_threshold(thr[yincmnd_pkg::THRESH_W-1:0]);
      src_idle_pct   = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 25 : 0;
      sink_stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 25 : 0;
      items_sent_phase = 0;
      // One frame runs past the lag limit so that the excess lags are seen.
      if (ph == 4) send_frame(MAX_LAG_TB + $urandom_range(1, 6));
      while (items_sent_phase < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        send_frame(len);
      end
      settle(30);
    end

    settle(40);
    if (sb.pending() != 0) begin
      $error("%0d frame results never arrived", sb.pending());
      sb.n_errors++;
    end
    $display("Run covered %0d lag values in %0d frames, %0d with a pitch (deepest lag %0d),",
             sb.n_items, sb.n_frames, sb.n_pitches, sb.deepest_lag);
    $display("over thresholds from 0 to full scale and four flow-control modes.");
    if (sb.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
